@@ src/cdq_pkg.sv @@
// Shared sizes, opcodes and status codes for the circular deque engine.
// No dependencies; imported by cdq_ram users and the top level.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH      = 8;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 4;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_LAST : i - 1'b1;
   endfunction

endpackage

`default_nettype wire

@@ src/cdq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/circular_deque_engine_top.sv @@
// Top level of the circular deque engine: index/count control and the ring RAM.
// Depends on cdq_pkg and cdq_ram.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------------------------
//   req     | in  | req_valid / req_stall | req_opcode, req_value
//   rsp     | out | rsp_valid / rsp_stall | rsp_status, rsp_removed_value,
//           |     |                       | rsp_occupancy, rsp_is_empty, rsp_is_full
//
// A push, or any refused operation, has its result beat registered at the
// edge that accepts it. A successful pop first moves to S_READ while the ring
// RAM registers its read data, and its result beat is registered from there.
// Reset clears the indices, the count and the control state; the ring needs
// no clearing, as a pop only ever reads slots already written.
// A new beat is accepted only once the previous result has been taken (or is
// taken in the same cycle); rsp_stall with a result pending thus holds req_stall high.
`default_nettype none

module circular_deque_engine_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [cdq_pkg::OP_W-1:0]         req_opcode,
   input  wire logic signed [cdq_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [cdq_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [cdq_pkg::DATA_WIDTH-1:0] rsp_removed_value,
   output logic      [cdq_pkg::OCC_W-1:0]        rsp_occupancy,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full
);

   import cdq_pkg::*;

   // sequencer states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;  // waiting for pop read data from the ring RAM

   logic                  state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [DATA_WIDTH-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;

   logic                  accept;
   logic                  out_free;
   logic                  is_push;
   logic                  is_front;
   logic                  empty_now;
   logic                  full_now;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // the output slot is free if empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign is_push   = !req_opcode[1];
   assign is_front  = (req_opcode == OP_PUSH_FRONT) || (req_opcode == OP_POP_FRONT);
   assign empty_now = (cnt_ff == '0);
   assign full_now  = (cnt_ff == CNT_FULL);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      removed_in   = removed_ff;
      occ_in       = occ_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               removed_in = '0;
               if (is_push) begin
                  if (full_now) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     status_in = ST_DONE;
                     wr_en     = 1'b1;
                     cnt_in    = cnt_ff + 1'b1;
                     if (empty_now) begin
                        // first element lands in slot 0 whichever end
                        head_in = '0;
                        tail_in = '0;
                        wr_addr = '0;
                     end else if (is_front) begin
                        head_in = idx_down(head_ff);
                        wr_addr = idx_down(head_ff);
                     end else begin
                        tail_in = idx_up(tail_ff);
                        wr_addr = idx_up(tail_ff);
                     end
                  end
                  occ_in       = cnt_in;
                  rsp_valid_in = 1'b1;
               end else begin
                  if (empty_now) begin
                     status_in    = ST_UNDERFLOW;
                     rsp_valid_in = 1'b1;
                  end else begin
                     status_in = ST_DONE;
                     rd_en     = 1'b1;
                     rd_addr   = is_front ? head_ff : tail_ff;
                     cnt_in    = cnt_ff - 1'b1;
                     state_in  = S_READ;
                     if (cnt_ff == CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else if (is_front) begin
                        head_in = idx_up(head_ff);
                     end else begin
                        tail_in = idx_down(tail_ff);
                     end
                  end
                  occ_in = cnt_in;
               end
            end
         end
         S_READ: begin
            removed_in   = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      removed_ff <= removed_in;
      occ_ff     <= occ_in;
   end

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_occupancy     = OCC_W'(occ_ff);
   assign rsp_is_empty      = (occ_ff == '0);
   assign rsp_is_full       = (occ_ff == CNT_FULL);

endmodule

`default_nettype wire
